[design/bss_pkg.sv]
// shared types, codes and constants of the backend server selector
`timescale 1ns / 1ps
package bss_pkg;

   localparam int NUM_SERVERS_DEF = 4;

   localparam int FUNC_W   = 2;
   localparam int ADDR_W   = 2;
   localparam int RESP_W   = 16;
   localparam int CONN_W   = 10;
   localparam int FAIL_W   = 8;
   localparam int STATUS_W = 2;

   // servers that a report or release can name
   localparam int ADDR_RANGE = 1 << ADDR_W;

   localparam logic [CONN_W-1:0] CONN_MAX = '1;
   localparam logic [FAIL_W-1:0] FAIL_MAX = '1;

   localparam logic [FUNC_W-1:0] FUNC_REPORT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE_UP   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   localparam int CSR_ADDR_W = 3;
   localparam logic REG_SELECT_MODE = 1'b0;

   localparam logic MODE_FASTEST = 1'b0;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] server_index;
      logic              up_flag;
      logic [RESP_W-1:0] resp_ms;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   chosen_server;
      logic [CONN_W-1:0]   conn_count;
      logic [FAIL_W-1:0]   fail_count;
   } rsp_type;

   // word handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] idx;
      logic              up;
      logic [RESP_W-1:0] resp;
      logic              found;
      logic              under;
      logic [RESP_W-1:0] best_resp;
      logic [CONN_W-1:0] conns;
      logic [FAIL_W-1:0] fails;
   } token_type;

endpackage

[design/bss_cell.sv]
// one server entry of the selector chain
`timescale 1ns / 1ps
module bss_cell import bss_pkg::*; #(
   parameter int NUM_SERVERS = NUM_SERVERS_DEF,
   parameter int INDEX = 0,
   localparam int IDX_W = $clog2(NUM_SERVERS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             mode,
   input  logic             inc_valid,
   input  logic [IDX_W-1:0] inc_idx,
   input  token_type        tok_in,
   input  logic [IDX_W-1:0] best_in,
   output token_type        tok_out,
   output logic [IDX_W-1:0] best_out
);

   logic              healthy_ff, healthy_in;
   logic [RESP_W-1:0] resp_ff, resp_in;
   logic [CONN_W-1:0] conns_ff, conns_in;
   logic [FAIL_W-1:0] fails_ff, fails_in;
   token_type         fwd_ff, fwd_in;
   logic [IDX_W-1:0]  pick_ff, pick_in;
   logic              match;
   logic              better;

   assign match = (INDEX < ADDR_RANGE) && (tok_in.idx == ADDR_W'(INDEX));

   always_comb begin
      if (mode == MODE_FASTEST) begin
         better = (resp_ff != '0) && ((tok_in.best_resp == '0) || (resp_ff < tok_in.best_resp));
      end else begin
         better = conns_ff < tok_in.conns;
      end
   end

   always_comb begin
      healthy_in = healthy_ff;
      resp_in    = resp_ff;
      conns_in   = conns_ff;
      fails_in   = fails_ff;
      fwd_in     = tok_in;
      pick_in    = best_in;
      if (tok_in.valid) begin
         case (tok_in.func)
            FUNC_DISPATCH: begin
               if (healthy_ff && (!tok_in.found || better)) begin
                  fwd_in.found     = 1'b1;
                  fwd_in.best_resp = resp_ff;
                  fwd_in.conns     = conns_ff;
                  fwd_in.fails     = fails_ff;
                  pick_in          = IDX_W'(INDEX);
               end
            end
            FUNC_REPORT: begin
               if (match) begin
                  healthy_in = tok_in.up;
                  if (tok_in.up) begin
                     fails_in = '0;
                     resp_in  = tok_in.resp;
                  end else begin
                     fails_in = (fails_ff == FAIL_MAX) ? FAIL_MAX : fails_ff + FAIL_W'(1);
                     resp_in  = '0;
                  end
                  fwd_in.conns = conns_ff;
                  fwd_in.fails = fails_in;
               end
            end
            FUNC_RELEASE: begin
               if (match) begin
                  if (conns_ff == '0) begin
                     fwd_in.under = 1'b1;
                  end else begin
                     conns_in = conns_ff - CONN_W'(1);
                  end
                  fwd_in.conns = conns_in;
                  fwd_in.fails = fails_ff;
               end
            end
            default: begin
               if (match) begin
                  fwd_in.conns = conns_ff;
                  fwd_in.fails = fails_ff;
               end
            end
         endcase
      end
      // dispatch commit from the chain end
      if (inc_valid && (inc_idx == IDX_W'(INDEX)) && (conns_ff != CONN_MAX)) begin
         conns_in = conns_ff + CONN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         healthy_ff <= 1'b0;
         resp_ff    <= '0;
         conns_ff   <= '0;
         fails_ff   <= '0;
      end else begin
         healthy_ff <= healthy_in;
         resp_ff    <= resp_in;
         conns_ff   <= conns_in;
         fails_ff   <= fails_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff  <= '0;
         pick_ff <= '0;
      end else begin
         fwd_ff  <= fwd_in;
         pick_ff <= pick_in;
      end
   end

   assign tok_out  = fwd_ff;
   assign best_out = pick_ff;

endmodule

[design/backend_server_selector.sv]
// top level of the backend server selector: csr, cell chain and result register
// a word passes the head register, each cell register and then the result register
// one word in flight at a time: the word walks the cell chain
// one cell per cycle and busy stays high until the result strobe
// reset: synchronous, clears the table, select_mode and all valid bits
// results are strobed for one cycle; the receiver cannot stall them
`timescale 1ns / 1ps
module backend_server_selector import bss_pkg::*; #(
   parameter int NUM_SERVERS = NUM_SERVERS_DEF,
   localparam int IDX_W = $clog2(NUM_SERVERS)
) (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_word,
   // result channel
   output logic                  rsp_strobe,
   output rsp_type               rsp_word,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   // configuration register
   logic mode_ff, mode_in;
   logic csr_write;
   logic csr_reg;

   assign pready    = 1'b1;
   assign csr_reg   = paddr[CSR_ADDR_W-1];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write && (csr_reg == REG_SELECT_MODE)) begin
         mode_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FASTEST;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign prdata = (csr_reg == REG_SELECT_MODE) ? {31'd0, mode_ff} : 32'd0;

   // command accept and busy tracking
   logic      accept;
   logic      busy_ff, busy_in;
   token_type head_ff, head_in;
   token_type tok_chain [NUM_SERVERS+1];
   logic [IDX_W-1:0] best_chain [NUM_SERVERS+1];
   token_type tail;
   logic [IDX_W-1:0] tail_best;

   assign accept = start && !busy_ff;
   assign tail      = tok_chain[NUM_SERVERS];
   assign tail_best = best_chain[NUM_SERVERS];

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tail.valid) begin
         busy_in = 1'b0;
      end
   end

   // fresh word entering the chain: nothing found yet, counts cleared
   always_comb begin
      head_in           = head_ff;
      head_in.valid     = accept;
      if (accept) begin
         head_in.func      = req_word.func;
         head_in.idx       = req_word.server_index;
         head_in.up        = req_word.up_flag;
         head_in.resp      = req_word.resp_ms;
         head_in.found     = 1'b0;
         head_in.under     = 1'b0;
         head_in.best_resp = '0;
         head_in.conns     = '0;
         head_in.fails     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         head_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         head_ff <= head_in;
      end
   end

   assign busy = busy_ff;

   // cell chain, one server per cell
   logic             inc_valid;
   logic [IDX_W-1:0] inc_idx;

   assign tok_chain[0]  = head_ff;
   assign best_chain[0] = '0;

   for (genvar g = 0; g < NUM_SERVERS; g++) begin : g_cell
      bss_cell #(
         .NUM_SERVERS(NUM_SERVERS),
         .INDEX      (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .mode     (mode_ff),
         .inc_valid(inc_valid),
         .inc_idx  (inc_idx),
         .tok_in   (tok_chain[g]),
         .best_in  (best_chain[g]),
         .tok_out  (tok_chain[g+1]),
         .best_out (best_chain[g+1])
      );
   end

   // chain end: build the result, commit the dispatch count
   rsp_type              rsp_ff, rsp_in;
   logic                 strobe_ff;
   logic [IDX_W+ADDR_W-1:0] best_ext;

   assign best_ext  = {{ADDR_W{1'b0}}, tail_best};
   assign inc_valid = tail.valid && (tail.func == FUNC_DISPATCH) && tail.found;
   assign inc_idx   = tail_best;

   always_comb begin
      rsp_in.status        = (tail.func == FUNC_RELEASE && tail.under) ? STATUS_UNDERFLOW
                                                                        : STATUS_OK;
      rsp_in.chosen_server = tail.idx;
      rsp_in.conn_count    = tail.conns;
      rsp_in.fail_count    = tail.fails;
      if (tail.func == FUNC_DISPATCH) begin
         if (tail.found) begin
            // chosen index masked to the result width
            rsp_in.status        = STATUS_OK;
            rsp_in.chosen_server = best_ext[ADDR_W-1:0];
            rsp_in.conn_count    = (tail.conns == CONN_MAX) ? CONN_MAX
                                                            : tail.conns + CONN_W'(1);
         end else begin
            rsp_in.status        = STATUS_NONE_UP;
            rsp_in.chosen_server = '0;
            rsp_in.conn_count    = '0;
            rsp_in.fail_count    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tail.valid) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= tail.valid;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

   // checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accept");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && !head_ff.valid)
      else $error("result strobed while a word is still in flight");

   a_none_up_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status == STATUS_NONE_UP) |->
         (rsp_word.chosen_server == '0 && rsp_word.conn_count == '0
          && rsp_word.fail_count == '0))
      else $error("no-healthy result carries server data");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results for one word");

endmodule

[dv/tb_backend_server_selector.sv]
// self-checking testbench of the backend server selector: directed cases, random traffic, saturation
`timescale 1ns / 1ps
module tb_backend_server_selector;
   import bss_pkg::*;

   // function code that the block treats as a plain lookup
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd3;
   localparam logic MODE_FEWEST = ~MODE_FASTEST;
   localparam logic [CSR_ADDR_W-1:0] SELECT_MODE_ADDR =
      CSR_ADDR_W'(4 * int'(REG_SELECT_MODE));
   // drain wait after the last reply, sized from the chain length plus some slack
   localparam int DRAIN_CYCLES = NUM_SERVERS_DEF + 2 + 4;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_PRINTS   = 40;

   logic                  clock   = 1'b0;
   logic                  reset   = 1'b1;
   logic                  start   = 1'b0;
   logic                  busy;
   req_type               req_word = '0;
   logic                  rsp_strobe;
   rsp_type               rsp_word;
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [31:0]           pwdata  = '0;
   logic [31:0]           prdata;
   logic                  pready;

   // shadow copy of the server table and the selection mode
   logic              tbl_healthy [ADDR_RANGE];
   logic [RESP_W-1:0] tbl_resp    [ADDR_RANGE];
   logic [CONN_W-1:0] tbl_conns   [ADDR_RANGE];
   logic [FAIL_W-1:0] tbl_fails   [ADDR_RANGE];
   logic              mode_shadow;

   // replies predicted for accepted words, oldest first
   rsp_type pending_replies [$];

   int error_count = 0;
   int cycle_count = 0;

   backend_server_selector u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog: a hung handshake or a lost reply ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // shadow table update for one accepted word; returns the reply it should cause
   function automatic rsp_type predict_reply(input req_type w);
      rsp_type r;
      logic    found;
      logic    take;
      int      best;
      int      k;
      r     = '0;
      found = 1'b0;
      best  = 0;
      k     = int'(w.server_index);
      case (w.func)
         FUNC_DISPATCH: begin
            // scan healthy servers; strict compares keep ties on the lowest index
            for (int i = 0; i < NUM_SERVERS_DEF; i++) begin
               if (tbl_healthy[i]) begin
                  if (mode_shadow == MODE_FASTEST)
                     // a stored zero time means nothing measured and never displaces an earlier pick
                     take = (tbl_resp[i] != '0) &&
                            (tbl_resp[best] == '0 || tbl_resp[i] < tbl_resp[best]);
                  else
                     take = tbl_conns[i] < tbl_conns[best];
                  if (!found || take) begin
                     best  = i;
                     found = 1'b1;
                  end
               end
            end
            if (!found) begin
               // nobody healthy: all other fields stay zero, table untouched
               r.status = STATUS_NONE_UP;
            end else begin
               if (tbl_conns[best] != CONN_MAX)
                  tbl_conns[best] = tbl_conns[best] + CONN_W'(1);
               r.status        = STATUS_OK;
               r.chosen_server = ADDR_W'(best);
               r.conn_count    = tbl_conns[best];
               r.fail_count    = tbl_fails[best];
            end
         end
         FUNC_REPORT: begin
            if (w.up_flag) begin
               tbl_fails[k] = '0;
               tbl_resp[k]  = w.resp_ms;
            end else begin
               if (tbl_fails[k] != FAIL_MAX)
                  tbl_fails[k] = tbl_fails[k] + FAIL_W'(1);
               tbl_resp[k] = '0;
            end
            tbl_healthy[k]  = w.up_flag;
            r.status        = STATUS_OK;
            r.chosen_server = w.server_index;
            r.conn_count    = tbl_conns[k];
            r.fail_count    = tbl_fails[k];
         end
         FUNC_RELEASE: begin
            // release on an idle server flags underflow and keeps the count at zero
            if (tbl_conns[k] == '0) begin
               r.status = STATUS_UNDERFLOW;
            end else begin
               r.status     = STATUS_OK;
               tbl_conns[k] = tbl_conns[k] - CONN_W'(1);
            end
            r.chosen_server = w.server_index;
            r.conn_count    = tbl_conns[k];
            r.fail_count    = tbl_fails[k];
         end
         default: begin
            // unused code only reads back the addressed entry
            r.status        = STATUS_OK;
            r.chosen_server = w.server_index;
            r.conn_count    = tbl_conns[k];
            r.fail_count    = tbl_fails[k];
         end
      endcase
      return r;
   endfunction

   function automatic req_type make_word(input logic [FUNC_W-1:0] func,
                                         input int idx, input logic up,
                                         input logic [RESP_W-1:0] resp);
      req_type w;
      w.func         = func;
      w.server_index = ADDR_W'(idx);
      w.up_flag      = up;
      w.resp_ms      = resp;
      return w;
   endfunction

   // drive one word from the falling edge and hold it until the block takes it;
   // busy is read at the falling edge, where it is stable across the next rising edge
   task automatic send_word(input req_type w, input int idle_pct);
      logic was_busy;
      // each cycle the sender idles with the given chance
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_word <= w;
      forever begin
         was_busy = busy;
         @(posedge clock);
         if (!was_busy)
            break;
         @(negedge clock);
      end
      pending_replies.insert(pending_replies.size(), predict_reply(w));
   endtask

   // stop sending and let every predicted reply come back
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_replies.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // two-phase register write, only while the block is drained
   task automatic write_select_mode(input logic mode);
      wait_drained();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= SELECT_MODE_ADDR;
      pwdata  <= {31'd0, mode};
      @(negedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      mode_shadow = mode;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // reply checker: every strobe must match the oldest prediction
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_strobe) begin
         if (pending_replies.size() == 0) begin
            error_count <= error_count + 1;
            if (error_count < MAX_PRINTS)
               $display("%0t: unexpected reply, expected none, actual %p", $time, rsp_word);
         end else begin
            exp_r = pending_replies.pop_front();
            if (rsp_word.status        !== exp_r.status ||
                rsp_word.chosen_server !== exp_r.chosen_server ||
                rsp_word.conn_count    !== exp_r.conn_count ||
                rsp_word.fail_count    !== exp_r.fail_count) begin
               error_count <= error_count + 1;
               if (error_count < MAX_PRINTS)
                  $display("%0t: reply mismatch, expected %p, actual %p",
                           $time, exp_r, rsp_word);
            end
         end
      end
   end

   // empty table: dispatch finds nobody, release underflows, lookup reads zeros
   task automatic test_empty_table();
      send_word(make_word(FUNC_DISPATCH, 0, 1'b1, 16'hFFFF), 0);
      send_word(make_word(FUNC_RELEASE, 3, 1'b0, 16'h0000), 0);
      send_word(make_word(FUNC_LOOKUP, 2, 1'b1, 16'h5A5A), 0);
   endtask

   // fastest-response selection: zero times, extremes, ties, a server going down
   task automatic test_fastest_choice();
      write_select_mode(MODE_FASTEST);
      // only zero times stored: lowest healthy index wins
      send_word(make_word(FUNC_REPORT, 0, 1'b1, 16'h0000), 0);
      send_word(make_word(FUNC_DISPATCH, 0, 1'b0, 16'h0000), 0);
      // any measured time beats a zero
      send_word(make_word(FUNC_REPORT, 1, 1'b1, 16'hFFFF), 0);
      send_word(make_word(FUNC_DISPATCH, 3, 1'b1, 16'hFFFF), 0);
      send_word(make_word(FUNC_REPORT, 2, 1'b1, 16'h0001), 0);
      send_word(make_word(FUNC_DISPATCH, 0, 1'b0, 16'h0000), 0);
      // equal times: lower index wins
      send_word(make_word(FUNC_REPORT, 3, 1'b1, 16'h0001), 0);
      send_word(make_word(FUNC_DISPATCH, 0, 1'b0, 16'h0000), 0);
      // failed check: resp ignored, fail count rises, server drops out
      send_word(make_word(FUNC_REPORT, 2, 1'b0, 16'hFFFF), 0);
      send_word(make_word(FUNC_DISPATCH, 0, 1'b0, 16'h0000), 0);
      send_word(make_word(FUNC_RELEASE, 3, 1'b0, 16'h0000), 0);
      send_word(make_word(FUNC_RELEASE, 0, 1'b1, 16'hFFFF), 0);
   endtask

   // fewest-connections selection
   task automatic test_fewest_choice();
      write_select_mode(MODE_FEWEST);
      send_word(make_word(FUNC_DISPATCH, 0, 1'b0, 16'h0000), 0);
      send_word(make_word(FUNC_DISPATCH, 0, 1'b0, 16'h0000), 0);
      send_word(make_word(FUNC_DISPATCH, 0, 1'b0, 16'h0000), 0);
      send_word(make_word(FUNC_RELEASE, 1, 1'b0, 16'h0000), 0);
      send_word(make_word(FUNC_RELEASE, 1, 1'b0, 16'h0000), 0);
      send_word(make_word(FUNC_LOOKUP, 1, 1'b0, 16'hFFFF), 0);
   endtask

   // random traffic under one mode and one sender idle rate
   task automatic test_random_traffic(input logic mode, input int count, input int idle_pct);
      req_type w;
      int      pick;
      write_select_mode(mode);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 35)
            w.func = FUNC_REPORT;
         else if (pick < 65)
            w.func = FUNC_DISPATCH;
         else if (pick < 92)
            w.func = FUNC_RELEASE;
         else
            w.func = FUNC_LOOKUP;
         w.server_index = ADDR_W'($urandom_range(0, ADDR_RANGE - 1));
         // mostly healthy reports so that dispatches have a real choice
         w.up_flag = ($urandom_range(0, 99) < 70);
         // small times give frequent ties, zero and all-ones hit the edges
         case ($urandom_range(0, 3))
            0:       w.resp_ms = '0;
            1:       w.resp_ms = '1;
            2:       w.resp_ms = RESP_W'($urandom_range(1, 8));
            default: w.resp_ms = RESP_W'($urandom);
         endcase
         send_word(w, idle_pct);
      end
   endtask

   // fail count pinned at its maximum, connection count pinned at its maximum
   task automatic test_saturation();
      write_select_mode(MODE_FEWEST);
      for (int i = 0; i < NUM_SERVERS_DEF; i++)
         send_word(make_word(FUNC_REPORT, i, 1'b0, 16'h0000), 0);
      send_word(make_word(FUNC_REPORT, 1, 1'b1, 16'h0100), 0);
      repeat (int'(FAIL_MAX) + 4)
         send_word(make_word(FUNC_REPORT, 0, 1'b0, 16'h0000), 0);
      // only server 1 is healthy, so every dispatch lands on it
      repeat (int'(CONN_MAX) + 6)
         send_word(make_word(FUNC_DISPATCH, 0, 1'b0, 16'h0000), 10);
      write_select_mode(MODE_FASTEST);
      repeat (3)
         send_word(make_word(FUNC_DISPATCH, 0, 1'b0, 16'h0000), 0);
      send_word(make_word(FUNC_RELEASE, 1, 1'b0, 16'h0000), 0);
      send_word(make_word(FUNC_REPORT, 0, 1'b1, 16'h0000), 0);
   endtask

   initial begin
      for (int i = 0; i < ADDR_RANGE; i++) begin
         tbl_healthy[i] = 1'b0;
         tbl_resp[i]    = '0;
         tbl_conns[i]   = '0;
         tbl_fails[i]   = '0;
      end
      mode_shadow = MODE_FASTEST;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_fastest_choice();
      test_fewest_choice();
      // sender idles often, then more often, then never
      test_random_traffic(MODE_FASTEST, 50, 36);
      test_random_traffic(MODE_FEWEST,  50, 36);
      test_random_traffic(MODE_FASTEST, 50, 53);
      test_random_traffic(MODE_FEWEST,  50, 53);
      test_random_traffic(MODE_FEWEST,  40, 0);
      test_random_traffic(MODE_FASTEST, 40, 0);
      test_saturation();
      wait_drained();

      if (error_count == 0 && pending_replies.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
